@@ rtl/cfc_pkg.sv @@
// Package with the constants and widths of the capture frequency counter.
`timescale 1ns / 1ps

package cfc_pkg;

   localparam int COUNTER_BITS  = 16;
   localparam int FRACTION_BITS = 8;

   localparam int CAPTURE_W   = 16;
   localparam int COUNT_W     = 16;
   localparam int MS_W        = 32;
   localparam int PERIOD_W    = 32;
   localparam int FREQ_W      = 40;
   localparam int TICK_RATE_W = 32;
   localparam int TIMEOUT_W   = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam int DIVIDEND_W = TICK_RATE_W + FRACTION_BITS;
   localparam int DIVISOR_W  = PERIOD_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W);
   localparam int CMP_W      = (DIVIDEND_W > FREQ_W) ? DIVIDEND_W : FREQ_W;

   localparam logic FUNC_CAPTURE  = 1'b0;
   localparam logic FUNC_OVERFLOW = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_RATE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT   = CSR_INDEX_W'(1);

   localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = TICK_RATE_W'(1000000);
   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = TIMEOUT_W'(100);

   typedef logic [FREQ_W-1:0]     freq_type;
   typedef logic [PERIOD_W-1:0]   period_type;
   typedef logic [DIVIDEND_W-1:0] dividend_type;
   typedef logic [DIVISOR_W-1:0]  divisor_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/cfc_channels.sv @@
// Valid-ready channel interfaces for events and results of the frequency counter.
`timescale 1ns / 1ps

interface cfc_req_if;
   import cfc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [CAPTURE_W-1:0] capture_value;
   logic [MS_W-1:0]      now_ms;

   modport source (output valid, func, capture_value, now_ms, input ready);
   modport sink (input valid, func, capture_value, now_ms, output ready);
endinterface

interface cfc_rsp_if;
   import cfc_pkg::*;

   logic                valid;
   logic                ready;
   logic                notify;
   logic [FREQ_W-1:0]   frequency;
   logic [PERIOD_W-1:0] period_ticks;

   modport source (output valid, notify, frequency, period_ticks, input ready);
   modport sink (input valid, notify, frequency, period_ticks, output ready);
endinterface

@@ rtl/cfc_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module cfc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  cfc_pkg::dividend_type  dividend,
   input  cfc_pkg::divisor_type   divisor,
   output cfc_pkg::div_status_type status,
   output cfc_pkg::dividend_type  quotient
);
   import cfc_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(DIVIDEND_W - 1);
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

@@ rtl/capture_frequency_counter.sv @@
// Top level of the reciprocal capture frequency counter.
`timescale 1ns / 1ps

// Each transaction on req_chan is a capture or an overflow event and yields exactly one
// transaction on rsp_chan. Overflow events and first captures go straight from idle to the
// emit state. A second capture runs the period through the restoring divider, which makes
// one quotient bit per cycle, and then goes on to the emit state.
// req_chan.ready is high only while no event is in progress; the result register lets the
// next event enter while an earlier result still waits to be taken. Configuration writes on
// csr_we take effect at once and are meant for idle periods.
module capture_frequency_counter (
   input logic                               clock,
   input logic                               reset,
   cfc_req_if.sink                           req_chan,
   cfc_rsp_if.source                         rsp_chan,
   input logic                               csr_we,
   input logic [cfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input logic [cfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cfc_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIVIDE = 2'd1;
   localparam logic [1:0] S_EMIT   = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic                   armed_ff, armed_in;
   logic [CAPTURE_W-1:0]   first_ff, first_in;
   logic [COUNT_W-1:0]     ovf_ff, ovf_in;
   freq_type               cur_freq_ff, cur_freq_in;
   freq_type               rep_freq_ff, rep_freq_in;
   logic [MS_W-1:0]        last_ms_ff, last_ms_in;
   period_type             last_period_ff, last_period_in;
   logic [MS_W-1:0]        now_ff, now_in;
   logic                   notify_ff, notify_in;
   logic [TICK_RATE_W-1:0] tick_rate_ff;
   logic [TIMEOUT_W-1:0]   timeout_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_notify_ff, rsp_notify_in;
   freq_type               rsp_freq_ff, rsp_freq_in;
   period_type             rsp_period_ff, rsp_period_in;

   logic                   accept;
   logic                   div_start;
   div_status_type         div_status;
   dividend_type           div_quotient;
   period_type             period_calc;
   logic [COUNT_W-1:0]     ovf_next;
   logic [CMP_W-1:0]       quot_wide;
   freq_type               freq_calc;

   cfc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIVIDEND_W'(tick_rate_ff) << FRACTION_BITS),
      .divisor  (last_period_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      period_calc = PERIOD_W'({ovf_ff, COUNTER_BITS'(0)})
         + PERIOD_W'(req_chan.capture_value) - PERIOD_W'(first_ff);
      ovf_next  = (ovf_ff == '1) ? ovf_ff : ovf_ff + COUNT_W'(1);
      quot_wide = CMP_W'(div_quotient);
      if (last_period_ff == '0) begin
         freq_calc = '0;
      end else if (quot_wide > CMP_W'({FREQ_W{1'b1}})) begin
         freq_calc = '1;
      end else begin
         freq_calc = FREQ_W'(quot_wide);
      end

      state_in       = state_ff;
      armed_in       = armed_ff;
      first_in       = first_ff;
      ovf_in         = ovf_ff;
      cur_freq_in    = cur_freq_ff;
      rep_freq_in    = rep_freq_ff;
      last_ms_in     = last_ms_ff;
      last_period_in = last_period_ff;
      now_in         = now_ff;
      notify_in      = notify_ff;
      div_start      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_notify_in  = rsp_notify_ff;
      rsp_freq_in    = rsp_freq_ff;
      rsp_period_in  = rsp_period_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in    = req_chan.now_ms;
               notify_in = 1'b0;
               state_in  = S_EMIT;
               if (req_chan.func == FUNC_CAPTURE) begin
                  if (!armed_ff) begin
                     first_in = req_chan.capture_value;
                     ovf_in   = '0;
                     armed_in = 1'b1;
                  end else begin
                     last_period_in = period_calc;
                     armed_in       = 1'b0;
                     state_in       = S_DIVIDE;
                  end
               end else begin
                  ovf_in = ovf_next;
                  if (cur_freq_ff != '0 && COUNT_W'(ovf_next) > COUNT_W'(timeout_ff)) begin
                     last_ms_in  = req_chan.now_ms;
                     first_in    = '0;
                     cur_freq_in = '0;
                     rep_freq_in = '0;
                     notify_in   = 1'b1;
                  end
               end
            end
         end
         S_DIVIDE: begin
            div_start = !div_status.busy && !div_status.done;
            if (div_status.done) begin
               cur_freq_in = freq_calc;
               if (freq_calc != rep_freq_ff && now_ff != last_ms_ff) begin
                  last_ms_in  = now_ff;
                  rep_freq_in = freq_calc;
                  notify_in   = 1'b1;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_notify_in = notify_ff;
               rsp_freq_in   = cur_freq_ff;
               rsp_period_in = last_period_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         armed_ff       <= 1'b0;
         first_ff       <= '0;
         ovf_ff         <= '0;
         cur_freq_ff    <= '0;
         rep_freq_ff    <= '0;
         last_ms_ff     <= '0;
         last_period_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         tick_rate_ff   <= TICK_RATE_RESET;
         timeout_ff     <= TIMEOUT_RESET;
      end else begin
         state_ff       <= state_in;
         armed_ff       <= armed_in;
         first_ff       <= first_in;
         ovf_ff         <= ovf_in;
         cur_freq_ff    <= cur_freq_in;
         rep_freq_ff    <= rep_freq_in;
         last_ms_ff     <= last_ms_in;
         last_period_ff <= last_period_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we && csr_index == CSR_TICK_RATE) begin
            tick_rate_ff <= csr_wdata[TICK_RATE_W-1:0];
         end
         if (csr_we && csr_index == CSR_TIMEOUT) begin
            timeout_ff <= csr_wdata[TIMEOUT_W-1:0];
         end
      end
      now_ff        <= now_in;
      notify_ff     <= notify_in;
      rsp_notify_ff <= rsp_notify_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_period_ff <= rsp_period_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.notify       = rsp_notify_ff;
   assign rsp_chan.frequency    = rsp_freq_ff;
   assign rsp_chan.period_ticks = rsp_period_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("Block stayed idle after accepting a transaction.");

   a_divider_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIVIDE)
      else $error("Divider finished outside the divide state.");

   a_divider_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == S_DIVIDE)
      else $error("Divider busy outside the divide state.");

   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !rsp_valid_ff) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("Result was not loaded into a free output register.");

endmodule
